// File: hw/rtl/serial_line_coding_encoder_assert.svh
// assertion macros for the line coding encoder
`ifndef SERIAL_LINE_CODING_ENCODER_ASSERT_SVH
`define SERIAL_LINE_CODING_ENCODER_ASSERT_SVH

// checked at every rising edge outside reset
`define SLCE_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every rising edge, reset included
`define SLCE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hw/rtl/slce_pkg.sv
// shared types, constants and the standard rate table of the line coding encoder
`timescale 1ns / 1ps

package slce_pkg;

    localparam int BAUD_W  = 24;
    localparam int STOP_W  = 2;
    localparam int PAR_W   = 3;
    localparam int DBITS_W = 4;
    localparam int WORD_W  = 32;
    localparam int ENC_W   = 2;
    localparam int KIND_W  = 3;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    // divider: 12000000 * 32 over the requested rate
    localparam int DIV_BITS = 29;
    localparam int CNT_W    = 5;
    localparam logic [DIV_BITS-1:0] BASELINE = DIV_BITS'(12000000 * 32);

    localparam int EXP_W      = 4;
    localparam int RATE_COUNT = 25;

    localparam logic [DIV_BITS-1:0] LIMIT4 = DIV_BITS'(512);
    localparam logic [DIV_BITS-1:0] SAT4   = DIV_BITS'(511);
    localparam logic [DIV_BITS-1:0] LIMIT2 = DIV_BITS'(2048);
    localparam logic [DIV_BITS-1:0] SAT2   = DIV_BITS'(2047);
    localparam logic [EXP_W-1:0]    EMAX4  = EXP_W'(7);
    localparam logic [EXP_W-1:0]    EMAX2  = EXP_W'(15);
    localparam logic [7:0]          DIV_MARK = 8'h80;

    localparam logic [KIND_W-1:0] KIND_TA  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TB  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HXN = 3'd5;

    localparam logic [ENC_W-1:0] ENC_DIRECT = 2'd0;
    localparam logic [ENC_W-1:0] ENC_BASE4  = 2'd1;
    localparam logic [ENC_W-1:0] ENC_BASE2  = 2'd2;

    localparam logic [STOP_W-1:0] STOP_TWO  = 2'd2;
    localparam logic [STOP_W-1:0] STOP_NONE = 2'd0;
    localparam logic [PAR_W-1:0]  PAR_NONE  = 3'd0;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_NORM = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    function automatic logic [BAUD_W-1:0] std_rate(input logic [CNT_W-1:0] idx);
        logic [BAUD_W-1:0] r;
        case (idx)
            5'd0:  r = 24'd75;
            5'd1:  r = 24'd150;
            5'd2:  r = 24'd300;
            5'd3:  r = 24'd600;
            5'd4:  r = 24'd1200;
            5'd5:  r = 24'd1800;
            5'd6:  r = 24'd2400;
            5'd7:  r = 24'd3600;
            5'd8:  r = 24'd4800;
            5'd9:  r = 24'd7200;
            5'd10: r = 24'd9600;
            5'd11: r = 24'd14400;
            5'd12: r = 24'd19200;
            5'd13: r = 24'd28800;
            5'd14: r = 24'd38400;
            5'd15: r = 24'd57600;
            5'd16: r = 24'd115200;
            5'd17: r = 24'd230400;
            5'd18: r = 24'd460800;
            5'd19: r = 24'd614400;
            5'd20: r = 24'd921600;
            5'd21: r = 24'd1228800;
            5'd22: r = 24'd2457600;
            5'd23: r = 24'd3000000;
            5'd24: r = 24'd6000000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/serial_line_coding_encoder.sv
// line coding encoder: rate table lookup, serial divide and divisor normalization
//
//  port group   | dir | contents
//  s_*          | in  | request item: baud rate, stop bits, parity, data bits
//  m_*          | out | line coding item: baud word, codes, encoding in tuser
//  cfg_*        | in  | chip kind register
//
//  one item in flight; s_tready is high only in the idle state
//  the 29-step restoring divider makes one quotient bit per cycle
//  the table scan runs alongside it, normalization shifts the quotient until it fits or saturates
//  the next item is taken while a result still waits on m_tready
//  aresetn is synchronous, active low, and clears the chip kind to 0
`timescale 1ns / 1ps
`include "serial_line_coding_encoder_assert.svh"

module serial_line_coding_encoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [slce_pkg::KIND_W-1:0]  cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // baud_rate [23:0], stop_bits [25:24], parity_mode [28:26], data_bits [32:29]
    input  logic [slce_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // baud_word [31:0], stop_code [33:32], parity_code [36:34], data_bits_code [40:37]
    output logic [slce_pkg::M_DATA_W-1:0] m_tdata,
    // encoding_used [1:0]
    output logic [slce_pkg::ENC_W-1:0]   m_tuser
);
    import slce_pkg::*;

    state_t                state_reg, state_next;
    logic [KIND_W-1:0]     kind_reg;
    logic [BAUD_W-1:0]     baud_reg, baud_next;
    logic [STOP_W-1:0]     stop_reg, stop_next;
    logic [PAR_W-1:0]      par_reg, par_next;
    logic [DBITS_W-1:0]    dbits_reg, dbits_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [BAUD_W-1:0]     rem_reg, rem_next;
    logic [DIV_BITS-1:0]   q_reg, q_next;
    logic [EXP_W-1:0]      e_reg, e_next;
    logic                  hit_reg, hit_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;
    logic [ENC_W-1:0]      m_user_reg, m_user_next;

    logic                  s_acc;
    logic                  base2_mode;
    logic                  direct;
    logic [CNT_W-1:0]      bit_idx;
    logic [BAUD_W:0]       trial;
    logic [BAUD_W+1:0]     diff;
    logic [WORD_W-1:0]     word;
    logic [ENC_W-1:0]      enc;
    logic [STOP_W-1:0]     stop_code;
    logic [PAR_W-1:0]      par_code;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_acc      = s_tvalid && s_tready;
    assign base2_mode = (kind_reg == KIND_TA) || (kind_reg == KIND_TB);
    assign direct     = hit_reg || (kind_reg == KIND_HXN);
    assign bit_idx    = CNT_W'(DIV_BITS - 1) - cnt_reg;
    assign trial      = {rem_reg, BASELINE[bit_idx]};
    assign diff       = {1'b0, trial} - {2'b00, baud_reg};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // result formatting
    always_comb begin
        stop_code = (stop_reg == STOP_TWO) ? STOP_TWO : STOP_NONE;
        case (par_reg) inside
            [3'd0:3'd4]: par_code = par_reg;
            default:     par_code = PAR_NONE;
        endcase
        if (direct) begin
            word = {8'h00, baud_reg};
            enc  = ENC_DIRECT;
        end else if (base2_mode) begin
            word = {DIV_MARK, 7'd0, e_reg[0], e_reg[3:1], 2'b00, q_reg[10:0]};
            enc  = ENC_BASE2;
        end else begin
            word = {DIV_MARK, 8'h00, 4'h0, e_reg[2:0], q_reg[8:0]};
            enc  = ENC_BASE4;
        end
    end

    always_comb begin
        state_next   = state_reg;
        baud_next    = baud_reg;
        stop_next    = stop_reg;
        par_next     = par_reg;
        dbits_next   = dbits_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        e_next       = e_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    baud_next  = s_tdata[BAUD_W-1:0];
                    stop_next  = s_tdata[BAUD_W +: STOP_W];
                    par_next   = s_tdata[BAUD_W+STOP_W +: PAR_W];
                    dbits_next = s_tdata[BAUD_W+STOP_W+PAR_W +: DBITS_W];
                    cnt_next   = '0;
                    rem_next   = '0;
                    q_next     = '0;
                    e_next     = '0;
                    hit_next   = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // one quotient bit per cycle, one table entry per cycle
                if (!diff[BAUD_W+1]) begin
                    rem_next = diff[BAUD_W-1:0];
                    q_next   = {q_reg[DIV_BITS-2:0], 1'b1};
                end else begin
                    rem_next = trial[BAUD_W-1:0];
                    q_next   = {q_reg[DIV_BITS-2:0], 1'b0};
                end
                if ((cnt_reg < CNT_W'(RATE_COUNT)) && (std_rate(cnt_reg) == baud_reg)) begin
                    hit_next = 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_BITS - 1)) begin
                    state_next = (hit_next || (kind_reg == KIND_HXN)) ? ST_DONE : ST_NORM;
                end
            end
            ST_NORM: begin
                if (base2_mode) begin
                    if (q_reg >= LIMIT2) begin
                        if (e_reg < EMAX2) begin
                            q_next = q_reg >> 1;
                            e_next = e_reg + 1'b1;
                        end else begin
                            q_next     = SAT2;
                            state_next = ST_DONE;
                        end
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    if (q_reg >= LIMIT4) begin
                        if (e_reg < EMAX4) begin
                            q_next = q_reg >> 2;
                            e_next = e_reg + 1'b1;
                        end else begin
                            q_next     = SAT4;
                            state_next = ST_DONE;
                        end
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, dbits_reg, par_code, stop_code, word};
                    m_user_next  = enc;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kind_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                kind_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        baud_reg   <= baud_next;
        stop_reg   <= stop_next;
        par_reg    <= par_next;
        dbits_reg  <= dbits_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        e_reg      <= e_next;
        hit_reg    <= hit_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    `SLCE_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE) && !m_valid_reg, "reset must leave the block idle with no item")
    `SLCE_ASSERT_RUN(a_load_from_done, $rose(m_valid_reg) |-> $past(state_reg == ST_DONE), "result appeared outside the done state")
    `SLCE_ASSERT_RUN(a_div_count, (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(DIV_BITS - 1)), "divider ran past its last step")
    `SLCE_ASSERT_RUN(a_word_mark, m_valid_reg |-> ((m_user_reg == ENC_DIRECT) ? (m_data_reg[31:24] == 8'h00) : (m_data_reg[31:24] == DIV_MARK)), "baud word top byte does not match its encoding")

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the line coding encoder: stream stimulus, predictor and scoreboard
`timescale 1ns / 1ps

module testbench;

    import slce_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PER_KIND    = 27;

    localparam logic [KIND_W-1:0] KIND_H      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HX     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HXD    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

    localparam logic [STOP_W-1:0] STOP_ONE = 2'd1;
    localparam logic [STOP_W-1:0] STOP_BAD = 2'd3;

    localparam logic [PAR_W-1:0] PAR_ODD   = 3'd1;
    localparam logic [PAR_W-1:0] PAR_EVEN  = 3'd2;
    localparam logic [PAR_W-1:0] PAR_MARK  = 3'd3;
    localparam logic [PAR_W-1:0] PAR_SPACE = 3'd4;
    localparam logic [PAR_W-1:0] PAR_RSV5  = 3'd5;
    localparam logic [PAR_W-1:0] PAR_RSV6  = 3'd6;
    localparam logic [PAR_W-1:0] PAR_RSV7  = 3'd7;

    localparam logic [BAUD_W-1:0] LISTED_RATES [0:RATE_COUNT-1] = '{
        24'd75, 24'd150, 24'd300, 24'd600, 24'd1200, 24'd1800, 24'd2400, 24'd3600,
        24'd4800, 24'd7200, 24'd9600, 24'd14400, 24'd19200, 24'd28800, 24'd38400,
        24'd57600, 24'd115200, 24'd230400, 24'd460800, 24'd614400, 24'd921600,
        24'd1228800, 24'd2457600, 24'd3000000, 24'd6000000
    };

    typedef struct packed {
        logic [DBITS_W-1:0] dbits;
        logic [PAR_W-1:0]   parity;
        logic [STOP_W-1:0]  stop;
        logic [BAUD_W-1:0]  baud;
    } line_request_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [STOP_W-1:0]  stop_code;
        logic [PAR_W-1:0]   parity_code;
        logic [DBITS_W-1:0] dbits_code;
        logic [ENC_W-1:0]   enc;
    } line_coding_t;

    class line_coding_book;
        logic [KIND_W-1:0] kind;
        line_coding_t      coding_queue[$];
        int unsigned       mismatches;
        int unsigned       checked;

        function new();
            kind = KIND_H;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_kind(logic [KIND_W-1:0] k);
            kind = k;
        endfunction

        function int pending();
            return coding_queue.size();
        endfunction

        function line_coding_t predict_line_coding(line_request_t r);
            line_coding_t c;
            logic [31:0]  q;
            logic [31:0]  m;
            logic [3:0]   e;
            logic [7:0]   byte1;
            bit           listed;
            listed = 1'b0;
            for (int i = 0; i < RATE_COUNT; i++) begin
                if (LISTED_RATES[i] == r.baud) listed = 1'b1;
            end
            q = (r.baud == '0) ? 32'hFFFF_FFFF : 32'(BASELINE) / 32'(r.baud);
            if (q == 0) q = 1;
            m = q;
            e = '0;
            if (kind == KIND_HXN || listed) begin
                c.word = 32'(r.baud);
                c.enc = ENC_DIRECT;
            end else if (kind == KIND_TA || kind == KIND_TB) begin
                while (m >= 32'(LIMIT2) && e < EMAX2) begin
                    m = m >> 1;
                    e = e + 1;
                end
                if (m >= 32'(LIMIT2)) m = 32'(SAT2);
                byte1 = 8'({e[3:1], 5'b0}) | 8'(m >> 8);
                c.word = {DIV_MARK, 7'd0, e[0], byte1, m[7:0]};
                c.enc = ENC_BASE2;
            end else begin
                while (m >= 32'(LIMIT4) && e < EMAX4) begin
                    m = m >> 2;
                    e = e + 1;
                end
                if (m >= 32'(LIMIT4)) m = 32'(SAT4);
                byte1 = 8'({e, 1'b0}) | 8'(m >> 8);
                c.word = {DIV_MARK, 8'h00, byte1, m[7:0]};
                c.enc = ENC_BASE4;
            end
            c.stop_code = (r.stop == STOP_TWO) ? STOP_TWO : STOP_NONE;
            c.parity_code = (r.parity <= PAR_SPACE) ? r.parity : PAR_NONE;
            c.dbits_code = r.dbits;
            return c;
        endfunction

        function void note_request(line_request_t r);
            coding_queue.insert(coding_queue.size(), predict_line_coding(r));
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            if (mismatches <= 100) $display("mismatch: %s", what);
        endtask

        task check_line_coding(line_coding_t got);
            line_coding_t want;
            checked++;
            if (coding_queue.size() == 0) begin
                flag_mismatch($sformatf("result with nothing expected, word %h", got.word));
            end else begin
                want = coding_queue.pop_front();
                if (got.word !== want.word)
                    flag_mismatch($sformatf("baud_word got %h want %h", got.word, want.word));
                if (got.stop_code !== want.stop_code)
                    flag_mismatch($sformatf("stop_code got %0d want %0d",
                                            got.stop_code, want.stop_code));
                if (got.parity_code !== want.parity_code)
                    flag_mismatch($sformatf("parity_code got %0d want %0d",
                                            got.parity_code, want.parity_code));
                if (got.dbits_code !== want.dbits_code)
                    flag_mismatch($sformatf("data_bits_code got %0d want %0d",
                                            got.dbits_code, want.dbits_code));
                if (got.enc !== want.enc)
                    flag_mismatch($sformatf("encoding_used got %0d want %0d",
                                            got.enc, want.enc));
            end
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [KIND_W-1:0]     cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [ENC_W-1:0]      m_tuser;

    line_coding_book book;
    int unsigned     cycle_count;
    int unsigned     requests_sent;
    int unsigned     kinds_written;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              hold_asks;
    int              hold_done;

    serial_line_coding_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                book.check_line_coding({m_tdata[31:0], m_tdata[33:32], m_tdata[36:34],
                                        m_tdata[40:37], m_tuser});
            if (s_tvalid && s_tready)
                book.note_request(line_request_t'(s_tdata[32:0]));
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // entered and left at a falling edge
    task send_request(line_request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_DATA_W'(r);
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        @(negedge aclk);
    endtask

    task send_fields(logic [BAUD_W-1:0] baud, logic [STOP_W-1:0] stop,
                     logic [PAR_W-1:0] parity, logic [DBITS_W-1:0] dbits);
        line_request_t r;
        r.baud = baud;
        r.stop = stop;
        r.parity = parity;
        r.dbits = dbits;
        send_request(r);
    endtask

    task write_chip_kind(logic [KIND_W-1:0] k);
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= k;
        book.set_kind(k);
        kinds_written++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic line_request_t random_request();
        line_request_t r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            r.baud = LISTED_RATES[$urandom_range(RATE_COUNT - 1)];
        else if (pick < 35)
            r.baud = LISTED_RATES[$urandom_range(RATE_COUNT - 1)]
                     + BAUD_W'($urandom_range(2)) - 24'd1;
        else if (pick < 50)
            r.baud = BAUD_W'($urandom_range(2000));
        else if (pick < 75)
            r.baud = BAUD_W'($urandom_range(12000000, 1));
        else if (pick < 97)
            r.baud = BAUD_W'($urandom);
        else if (pick == 97)
            r.baud = '0;
        else
            r.baud = '1;
        r.stop = ($urandom_range(3) == 0) ? STOP_W'($urandom) : STOP_W'($urandom_range(2, 1));
        r.parity = ($urandom_range(9) < 7) ? PAR_W'($urandom_range(4)) : PAR_W'($urandom);
        r.dbits = ($urandom_range(3) != 0) ? DBITS_W'($urandom_range(8, 5))
                                           : DBITS_W'($urandom);
        return r;
    endfunction

    logic [KIND_W-1:0] kind_order [0:7] = '{
        KIND_H, KIND_HXN, KIND_TA, KIND_SPARE7, KIND_HX, KIND_TB, KIND_HXD, KIND_SPARE6
    };

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cycle_count = 0;
        requests_sent = 0;
        kinds_written = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asks = 0;
        hold_done = 0;
        aclk = 1'b0;
        book = new();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: table edges, saturation, zero rate, unused kinds, bad codes
        write_chip_kind(KIND_H);
        send_fields(24'd75, STOP_ONE, PAR_NONE, 4'd8);
        send_fields(24'd6000000, STOP_TWO, PAR_ODD, 4'd5);
        send_fields(24'd1, STOP_NONE, PAR_EVEN, 4'd8);
        send_fields(24'd0, STOP_BAD, PAR_MARK, 4'd7);
        send_fields(24'hFFFFFF, STOP_ONE, PAR_SPACE, 4'd6);
        send_fields(24'd12000000, STOP_TWO, PAR_RSV5, 4'd0);
        send_fields(24'd50, STOP_ONE, PAR_RSV6, 4'd15);
        send_fields(24'd9601, STOP_ONE, PAR_RSV7, 4'd1);
        write_chip_kind(KIND_TA);
        send_fields(24'd0, STOP_TWO, PAR_NONE, 4'd8);
        send_fields(24'd1, STOP_ONE, PAR_ODD, 4'd7);
        send_fields(24'd100, STOP_ONE, PAR_EVEN, 4'd8);
        send_fields(24'hFFFFFF, STOP_TWO, PAR_NONE, 4'd5);
        send_fields(24'd7200, STOP_ONE, PAR_MARK, 4'd8);
        write_chip_kind(KIND_HXN);
        send_fields(24'd0, STOP_ONE, PAR_NONE, 4'd8);
        send_fields(24'd12345, STOP_TWO, PAR_SPACE, 4'd6);
        send_fields(24'hFFFFFF, STOP_ONE, PAR_RSV7, 4'd8);
        write_chip_kind(KIND_SPARE7);
        send_fields(24'd1000, STOP_ONE, PAR_NONE, 4'd8);
        send_fields(24'd0, STOP_TWO, PAR_ODD, 4'd7);
        write_chip_kind(KIND_SPARE6);
        send_fields(24'd1000, STOP_ONE, PAR_EVEN, 4'd8);
        write_chip_kind(KIND_TB);
        send_fields(24'd187500, STOP_TWO, PAR_NONE, 4'd8);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 70 : 0;
            recv_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 38 : 0;
            for (int k = 0; k < 8; k++) begin
                write_chip_kind(kind_order[(k + mode * 3) % 8]);
                if (k == 3 && mode != 1) hold_asks++;
                repeat (PER_KIND) send_request(random_request());
            end
        end

        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);

        $display("sent %0d line settings over %0d chip kind writes, %0d results checked",
                 requests_sent, kinds_written, book.checked);
        $display("covered listed and unlisted rates, zero and top rates, all codes");
        if (book.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
